// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, codes and shared types.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int MAG_W = OPERAND_WIDTH;
  localparam int PROD_W = 2 * MAG_W;
  localparam int WIDE_W = 2 * OPERAND_WIDTH + 1;
  localparam int CNT_W = $clog2(WIDE_W + 1);
  localparam int NUM_W = 33;
  localparam int DEN_W = 32;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_GCD_INIT, ST_GCD_TEST, ST_GCD_MOD,
    ST_DIVN, ST_DIVD, ST_COMBINE, ST_PROD, ST_DONE
  } state_t;

  // Selects which fraction the shared reduction works on.
  typedef enum logic [1:0] { SEL_A, SEL_B, SEL_R } sel_t;

  // Selects the dividend and divisor loaded into the shared divider.
  typedef enum logic [1:0] { DIV_MOD, DIV_NUM, DIV_DEN } div_src_t;

  typedef struct packed {
    logic       load;
    logic       gcd_start;
    logic       gcd_update;
    logic       div_start;
    div_src_t   div_src;
    logic       div_step;
    logic       quo_keep;
    logic       store;
    sel_t       sel;
    logic       combine;
    logic       prod;
    logic       set_status;
    logic [1:0] status_code;
  } cmd_t;

  typedef struct packed {
    logic zero_den;
    logic div_zero;
    logic gy_zero;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/rau_ctrl.sv =====
// Controller state machine for the rational arithmetic unit.
module rau_ctrl import rau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;
  sel_t sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel <= SEL_A;
    end else begin
      state <= state_next;
      sel <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next = sel;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        sel_next = SEL_A;
        state_next = st.zero_den ? ST_DONE : ST_GCD_INIT;
      end
      ST_GCD_INIT: state_next = ST_GCD_TEST;
      ST_GCD_TEST: state_next = st.gy_zero ? ST_DIVN : ST_GCD_MOD;
      ST_GCD_MOD: if (st.div_done) state_next = ST_GCD_TEST;
      ST_DIVN: if (st.div_done) state_next = ST_DIVD;
      ST_DIVD: begin
        if (st.div_done) begin
          case (sel)
            SEL_A: begin
              sel_next = SEL_B;
              state_next = ST_GCD_INIT;
            end
            SEL_B: state_next = ST_COMBINE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_COMBINE: state_next = st.div_zero ? ST_DONE : ST_PROD;
      ST_PROD: begin
        sel_next = SEL_R;
        state_next = ST_GCD_INIT;
      end
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.sel = sel;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_DONE);
    case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_CHECK: begin
        cmd.set_status = st.zero_den;
        cmd.status_code = STATUS_ZERO_DEN;
      end
      ST_GCD_INIT: cmd.gcd_start = 1'b1;
      ST_GCD_TEST: begin
        cmd.div_start = 1'b1;
        cmd.div_src = st.gy_zero ? DIV_NUM : DIV_MOD;
      end
      ST_GCD_MOD: begin
        cmd.div_step = !st.div_done;
        cmd.gcd_update = st.div_done;
      end
      ST_DIVN: begin
        cmd.div_step = !st.div_done;
        cmd.quo_keep = st.div_done;
        cmd.div_start = st.div_done;
        cmd.div_src = DIV_DEN;
      end
      ST_DIVD: begin
        cmd.div_step = !st.div_done;
        cmd.store = st.div_done && (sel != SEL_R);
        cmd.set_status = st.div_done && (sel == SEL_R);
        cmd.status_code = STATUS_OK;
      end
      ST_COMBINE: begin
        cmd.combine = 1'b1;
        cmd.set_status = st.div_zero;
        cmd.status_code = STATUS_DIV_ZERO;
      end
      ST_PROD: cmd.prod = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/rau_datapath.sv =====
// Datapath for the rational arithmetic unit: operand registers, GCD and divider.
module rau_datapath import rau_pkg::*; (
  input  logic                     clk,
  input  logic [1:0]               kind,
  input  logic [OPERAND_WIDTH-1:0] left_num,
  input  logic [OPERAND_WIDTH-1:0] left_den,
  input  logic [OPERAND_WIDTH-1:0] right_num,
  input  logic [OPERAND_WIDTH-1:0] right_den,
  input  cmd_t                     cmd,
  output stat_t                    st,
  output logic signed [NUM_W-1:0]  result_num,
  output logic [DEN_W-1:0]         result_den,
  output logic [1:0]               status
);

  logic [1:0] op;
  logic a_neg, b_neg, r_neg;
  logic [MAG_W-1:0] a_num, a_den, b_num, b_den;
  logic [WIDE_W-1:0] r_num, r_den;
  logic [WIDE_W-1:0] t1, t2;
  logic [WIDE_W-1:0] gx, gy;
  logic [WIDE_W-1:0] dq, drem, dd, dn, quo_num;
  logic [CNT_W-1:0] dcnt;
  logic [WIDE_W:0] trial;
  logic [WIDE_W-1:0] cur_num, cur_den;
  logic [PROD_W-1:0] p_cross_l, p_cross_r, p_num, p_den;
  logic b_sign_eff;
  logic [MAG_W-1:0] ln_m, ld_m, rn_m, rd_m;

  // Magnitude of a two's complement operand; the most negative value maps to 2^(W-1).
  function automatic logic [MAG_W-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
    return v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  assign ln_m = mag_of(left_num);
  assign ld_m = mag_of(left_den);
  assign rn_m = mag_of(right_num);
  assign rd_m = mag_of(right_den);

  // Current fraction under reduction, widened.
  always_comb begin
    case (cmd.sel)
      SEL_A: begin
        cur_num = WIDE_W'(a_num);
        cur_den = WIDE_W'(a_den);
      end
      SEL_B: begin
        cur_num = WIDE_W'(b_num);
        cur_den = WIDE_W'(b_den);
      end
      default: begin
        cur_num = r_num;
        cur_den = r_den;
      end
    endcase
  end

  assign p_cross_l = a_num * b_den;
  assign p_cross_r = b_num * a_den;
  assign p_num = a_num * b_num;
  assign p_den = a_den * b_den;

  // Sign of the right term as it enters the sum; subtraction flips it.
  assign b_sign_eff = b_neg ^ (op == KIND_SUB);

  // Restoring divider, one quotient bit per cycle; shared by the gcd modulo
  // and by the two quotients of each reduction.
  assign trial = {drem, dn[WIDE_W-1]} - {1'b0, dd};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= kind;
      a_neg <= left_num[OPERAND_WIDTH-1] ^ left_den[OPERAND_WIDTH-1];
      b_neg <= right_num[OPERAND_WIDTH-1] ^ right_den[OPERAND_WIDTH-1];
      a_num <= ln_m;
      a_den <= ld_m;
      b_num <= rn_m;
      b_den <= rd_m;
    end else if (cmd.store) begin
      case (cmd.sel)
        SEL_A: begin
          a_num <= quo_num[MAG_W-1:0];
          a_den <= dq[MAG_W-1:0];
          if (quo_num == '0) a_neg <= 1'b0;
        end
        SEL_B: begin
          b_num <= quo_num[MAG_W-1:0];
          b_den <= dq[MAG_W-1:0];
          if (quo_num == '0) b_neg <= 1'b0;
        end
        default: ;
      endcase
    end else if (cmd.combine && op == KIND_DIV) begin
      // Division is multiplication by the reciprocal of the right operand.
      b_num <= b_den;
      b_den <= b_num;
    end

    if (cmd.combine) begin
      t1 <= WIDE_W'(p_cross_l);
      t2 <= WIDE_W'(p_cross_r);
    end

    if (cmd.prod) begin
      r_den <= WIDE_W'(p_den);
      if (op == KIND_MUL || op == KIND_DIV) begin
        r_num <= WIDE_W'(p_num);
        r_neg <= a_neg ^ b_neg;
      end else if (a_neg == b_sign_eff) begin
        r_num <= t1 + t2;
        r_neg <= a_neg;
      end else if (t1 >= t2) begin
        r_num <= t1 - t2;
        r_neg <= a_neg;
      end else begin
        r_num <= t2 - t1;
        r_neg <= b_sign_eff;
      end
    end

    if (cmd.gcd_start) begin
      gx <= cur_num;
      gy <= cur_den;
    end else if (cmd.gcd_update) begin
      gx <= gy;
      gy <= drem;
    end

    if (cmd.div_start) begin
      case (cmd.div_src)
        DIV_MOD: begin
          dn <= gx;
          dd <= gy;
        end
        DIV_NUM: begin
          dn <= cur_num;
          dd <= gx;
        end
        default: begin
          dn <= cur_den;
          dd <= gx;
        end
      endcase
      drem <= '0;
      dq <= '0;
      dcnt <= CNT_W'(WIDE_W);
    end else if (cmd.div_step && dcnt != '0) begin
      drem <= trial[WIDE_W] ? {drem[WIDE_W-2:0], dn[WIDE_W-1]} : trial[WIDE_W-1:0];
      dq <= {dq[WIDE_W-2:0], ~trial[WIDE_W]};
      dn <= {dn[WIDE_W-2:0], 1'b0};
      dcnt <= dcnt - 1'b1;
    end

    if (cmd.quo_keep) quo_num <= dq;

    if (cmd.set_status) begin
      status <= cmd.status_code;
      if (cmd.status_code == STATUS_OK) begin
        result_num <= r_neg ? -NUM_W'(quo_num) : NUM_W'(quo_num);
        result_den <= DEN_W'(dq);
      end else begin
        result_num <= '0;
        result_den <= DEN_W'(1);
      end
    end
  end

  assign st.zero_den = (a_den == '0) || (b_den == '0);
  assign st.div_zero = (op == KIND_DIV) && (b_num == '0);
  assign st.gy_zero = (gy == '0);
  assign st.div_done = (dcnt == '0);

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: controller plus datapath.
//
//  channel | signals                                   | direction
//  input   | in_valid, in_ready, kind, left_*, right_* | request in
//  output  | out_valid, out_ready, result_*, status    | request out
//
// One request is worked at a time; in_ready is high only while idle.
// Each fraction (left, right, result) is reduced by Euclid's algorithm: every
// step and both final quotients use one shared restoring divider, one
// quotient bit per cycle over 33 bits. A good request runs three such
// reductions; a zero denominator skips them and answers with STATUS_ZERO_DEN.
// Reset (rst, synchronous) returns the controller to idle; payload needs none.
// A result holds on the outputs until out_ready takes it.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic [OPERAND_WIDTH-1:0] left_num,
  input  logic [OPERAND_WIDTH-1:0] left_den,
  input  logic [OPERAND_WIDTH-1:0] right_num,
  input  logic [OPERAND_WIDTH-1:0] right_den,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [NUM_W-1:0]  result_num,
  output logic [DEN_W-1:0]         result_den,
  output logic [1:0]               status
);

  cmd_t  cmd;
  stat_t st;

  rau_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .st(st), .cmd(cmd)
  );

  rau_datapath u_dp (
    .clk(clk), .kind(kind), .left_num(left_num), .left_den(left_den),
    .right_num(right_num), .right_den(right_den), .cmd(cmd), .st(st),
    .result_num(result_num), .result_den(result_den), .status(status)
  );

`ifndef SYNTH
  a_ready_out: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_num))
    else $error("result dropped");
  a_den: assert property (@(posedge clk) disable iff (rst) out_valid |-> result_den != '0)
    else $error("zero denominator out");
`endif

endmodule
